// ===== rtl/scb_pkg.sv =====
package scb_pkg;

  localparam int ROW_PIXELS = 32;
  localparam int ROW_COUNT  = 32;
  localparam int MAX_RADIUS = 15;

  localparam int ROW_AW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int COL_W  = $clog2(ROW_PIXELS);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int REM_W  = 2 * RAD_W;
  // Holds a saturated width or height (up to 32) and the raw 6-bit registers.
  localparam int DIM_W  = 7;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_HIT    = 2'd1;
  localparam logic [1:0] OP_DAMAGE = 2'd2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

  typedef struct packed {
    logic [1:0]         op;
    logic [4:0]         row_index;
    logic [31:0]        row_bits;
    logic signed [11:0] origin_x;
    logic signed [11:0] origin_y;
    logic signed [11:0] point_x;
    logic signed [11:0] point_y;
    logic signed [11:0] damage_x;
    logic signed [11:0] damage_y;
    logic [3:0]         radius;
  } in_word_t;

  typedef struct packed {
    logic [1:0] done_op;
    logic       hit;
  } out_word_t;

  typedef struct packed {
    logic signed [11:0] cx;
    logic [REM_W-1:0]   rem;
    logic [DIM_W-1:0]   width;
  } mask_req_t;

  // Column x of the stored row takes bit 31-x of the loaded word.
  function automatic logic [ROW_PIXELS-1:0] load_word(input logic [31:0] bits);
    logic [ROW_PIXELS-1:0] w;
    w = '0;
    for (int i = 0; i < ROW_PIXELS; i++) begin
      if (i < 32) begin
        w[ROW_PIXELS-1-i] = bits[31-i];
      end
    end
    return w;
  endfunction

endpackage

// ===== rtl/scb_ram.sv =====
module scb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/scb_row_mask.sv =====
module scb_row_mask import scb_pkg::*; (
  input  mask_req_t             req,
  output logic [ROW_PIXELS-1:0] mask
);

  logic [RAD_W-1:0]   hw;
  logic signed [13:0] lo;
  logic signed [13:0] hi;
  logic signed [13:0] xs;

  // Half chord of the circle on this row: the largest k with k*k <= rem.
  always_comb begin
    hw = '0;
    for (int k = 1; k <= MAX_RADIUS; k++) begin
      if (REM_W'(k * k) <= req.rem) begin
        hw = RAD_W'(k);
      end
    end
  end

  assign lo = 14'(req.cx) - $signed({1'b0, 13'(hw)});
  assign hi = 14'(req.cx) + $signed({1'b0, 13'(hw)});

  always_comb begin
    mask = '0;
    xs   = '0;
    for (int x = 0; x < ROW_PIXELS; x++) begin
      xs = 14'(x);
      mask[ROW_PIXELS-1-x] = (xs >= lo) && (xs <= hi) && (DIM_W'(x) < req.width);
    end
  end

endmodule

// ===== rtl/sprite_collision_bitmap.sv =====
// Path from accepted word to result word: load and unused op go straight to FINISH,
// hit test reads its row in S_HIT, damage runs S_DMG_INIT, S_DMG_ROW per row and S_DMG_LAST.
// One item at a time; damage walks one row per cycle through the row RAM, reading
// the next row while writing back the previous one.
// A finished result waits in the output register while the next word is taken.
// Synchronous active-low reset clears the sequencer and output valid, and sets
// width and height to 32; the bitmap rows are undefined until loaded.
module sprite_collision_bitmap import scb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [5:0]           cfg_data
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_HIT      = 3'd1;
  localparam logic [2:0] S_DMG_INIT = 3'd2;
  localparam logic [2:0] S_DMG_ROW  = 3'd3;
  localparam logic [2:0] S_DMG_LAST = 3'd4;
  localparam logic [2:0] S_FINISH   = 3'd5;

  logic [2:0]            state_r, state_nxt;
  in_word_t              item_r, item_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_data_r, out_data_nxt;
  logic                  res_hit_r, res_hit_nxt;
  logic                  in_range_r, in_range_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [RAD_W-1:0]      r_r, r_nxt;
  logic [REM_W-1:0]      r2_r, r2_nxt;
  logic signed [RAD_W:0] dy_r, dy_nxt;
  logic                  wr_pend_r, wr_pend_nxt;
  logic [ROW_AW-1:0]     wr_addr_r, wr_addr_nxt;
  logic [ROW_PIXELS-1:0] mask_r, mask_nxt;
  logic [5:0]            width_r, height_r;

  logic                  accept;
  logic [DIM_W-1:0]      w_eff, h_eff;
  logic signed [12:0]    rx, ry, y_sum;
  logic                  hit_in_range, y_valid;
  logic [RAD_W-1:0]      r_sat;
  logic signed [RAD_W:0] dy_neg, r_ext;
  logic [RAD_W-1:0]      dy_abs, sq_in;
  logic [REM_W-1:0]      sq_out;
  logic [COL_W-1:0]      bit_idx;
  logic [ROW_PIXELS-1:0] row_mask;
  mask_req_t             mreq;

  logic                  ram_we, ram_re;
  logic [ROW_AW-1:0]     ram_waddr, ram_raddr;
  logic [ROW_PIXELS-1:0] ram_wdata, ram_rdata;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign w_eff = ({1'b0, width_r} > DIM_W'(ROW_PIXELS)) ? DIM_W'(ROW_PIXELS) : {1'b0, width_r};
  assign h_eff = ({1'b0, height_r} > DIM_W'(ROW_COUNT)) ? DIM_W'(ROW_COUNT) : {1'b0, height_r};

  assign rx = $signed({in_data.point_x[11], in_data.point_x})
            - $signed({in_data.origin_x[11], in_data.origin_x});
  assign ry = $signed({in_data.point_y[11], in_data.point_y})
            - $signed({in_data.origin_y[11], in_data.origin_y});
  assign hit_in_range = !rx[12] && !ry[12] && (rx[11:0] < 12'(w_eff))
                     && (ry[11:0] < 12'(h_eff));

  assign r_sat = (6'(in_data.radius) > 6'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                       : RAD_W'(in_data.radius);

  // The one squarer serves r*r at the start and dy*dy on every row.
  assign r_ext  = $signed({1'b0, r_r});
  assign dy_neg = -dy_r;
  assign dy_abs = dy_r[RAD_W] ? dy_neg[RAD_W-1:0] : dy_r[RAD_W-1:0];
  assign sq_in  = (state_r == S_DMG_INIT) ? r_r : dy_abs;
  assign sq_out = REM_W'(sq_in) * REM_W'(sq_in);

  assign y_sum   = $signed({item_r.damage_y[11], item_r.damage_y}) + 13'(dy_r);
  assign y_valid = !y_sum[12] && (y_sum[11:0] < 12'(h_eff));

  assign mreq.cx    = item_r.damage_x;
  assign mreq.rem   = r2_r - sq_out;
  assign mreq.width = w_eff;

  scb_row_mask u_mask (
    .req  (mreq),
    .mask (row_mask)
  );

  assign bit_idx = COL_W'(ROW_PIXELS - 1) - col_r;

  // Damage write-back of the row read in the previous cycle has priority; a load
  // can only arrive while idle, so the two never meet.
  always_comb begin
    if (wr_pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = wr_addr_r;
      ram_wdata = ram_rdata & ~mask_r;
    end else begin
      ram_we    = accept && (in_data.op == OP_LOAD)
               && (7'(in_data.row_index) < 7'(ROW_COUNT));
      ram_waddr = ROW_AW'(in_data.row_index);
      ram_wdata = load_word(in_data.row_bits);
    end
  end

  assign ram_re    = (accept && (in_data.op == OP_HIT)) || (state_r == S_DMG_ROW);
  assign ram_raddr = (state_r == S_DMG_ROW) ? ROW_AW'(y_sum) : ROW_AW'(ry);

  scb_ram #(
    .WIDTH (ROW_PIXELS),
    .DEPTH (ROW_COUNT)
  ) u_rows (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    res_hit_nxt   = res_hit_r;
    in_range_nxt  = in_range_r;
    col_nxt       = col_r;
    r_nxt         = r_r;
    r2_nxt        = r2_r;
    dy_nxt        = dy_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    mask_nxt      = mask_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt    = in_data;
          res_hit_nxt = 1'b0;
          case (in_data.op)
            OP_HIT: begin
              in_range_nxt = hit_in_range;
              col_nxt      = COL_W'(rx);
              state_nxt    = S_HIT;
            end
            OP_DAMAGE: begin
              r_nxt     = r_sat;
              state_nxt = S_DMG_INIT;
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end
      end
      S_HIT: begin
        res_hit_nxt = in_range_r && ram_rdata[bit_idx];
        state_nxt   = S_FINISH;
      end
      S_DMG_INIT: begin
        r2_nxt    = sq_out;
        dy_nxt    = -r_ext;
        state_nxt = S_DMG_ROW;
      end
      S_DMG_ROW: begin
        wr_pend_nxt = y_valid;
        wr_addr_nxt = ROW_AW'(y_sum);
        mask_nxt    = row_mask;
        if (dy_r == r_ext) begin
          state_nxt = S_DMG_LAST;
        end else begin
          dy_nxt = dy_r + (RAD_W+1)'(1);
        end
      end
      S_DMG_LAST: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.done_op = item_r.op;
          out_data_nxt.hit     = res_hit_r;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wr_pend_r   <= 1'b0;
      width_r     <= 6'd32;
      height_r    <= 6'd32;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wr_pend_r   <= wr_pend_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  width_r  <= cfg_data;
          CFG_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
    res_hit_r  <= res_hit_nxt;
    in_range_r <= in_range_nxt;
    col_r      <= col_nxt;
    r_r        <= r_nxt;
    r2_r       <= r2_nxt;
    dy_r       <= dy_nxt;
    wr_addr_r  <= wr_addr_nxt;
    mask_r     <= mask_nxt;
  end

  // A pending write-back only exists while a damage walk is finishing its rows.
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> (state_r == S_DMG_ROW || state_r == S_DMG_LAST))
    else $error("row write-back pending outside a damage walk");

  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.op == OP_LOAD) |=> (state_r == S_FINISH))
    else $error("load did not go straight to finish");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.hit || out_data_r.done_op == OP_HIT))
    else $error("hit flag set on a result that is not a hit test");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DMG_ROW) |-> (dy_r <= r_ext))
    else $error("damage row offset ran past the radius");

endmodule
